// File: hdl/path_length_and_smoothness_macros.svh
// Assertion macros for the path length and smoothness block.
// Used by pls_ctrl and pls_dpath; expects clk_i and rst_ni in scope.
`ifndef PATH_LENGTH_AND_SMOOTHNESS_MACROS_SVH
`define PATH_LENGTH_AND_SMOOTHNESS_MACROS_SVH

`ifndef ASSERT_OFF
`define PLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pls assertion failed");
`define PLS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pls assertion failed");
`else
`define PLS_ASSERT(lbl, prop)
`define PLS_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: hdl/pls_pkg.sv
// Shared types, constants and tables of the path length and smoothness block.
// No dependencies.
package pls_pkg;

  localparam int ACC_W     = 128;
  localparam int OPW       = 34;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 32;
  localparam int AVG_W     = 17;
  localparam int SQ_ITERS  = 64;
  localparam int DIV_ITERS = 49;
  localparam int ATAN_N    = 24;
  localparam int NOPND     = 16;

  localparam int MAC_D_FIRST = 0;
  localparam int MAC_D_LAST  = 2;
  localparam int MAC_X_FIRST = 3;
  localparam int MAC_X_LAST  = 11;
  localparam int MAC_N_FIRST = 12;
  localparam int MAC_N_LAST  = 20;

  localparam logic signed [31:0] HALF_TURN = 32'sd268435456;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [AVG_W-1:0]   AVG_ONE   = 17'd65536;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_PATH_NEW, DP_MAC, DP_SQ_INIT, DP_SQ_STEP, DP_LEN_ADD,
    DP_ANG_PREP, DP_NORM_STEP, DP_COR_INIT, DP_COR_STEP, DP_TERM_ADD,
    DP_CNT_UPD, DP_DIV_INIT, DP_DIV_STEP, DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [6:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic new_path;
    logic cnt_ge2;
    logic cnt_ge3;
    logic ang_zero;
    logic norm_done;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_D2, OP_A0, OP_A1, OP_A2, OP_B0, OP_B1, OP_B2,
    OP_H0, OP_H1, OP_H2, OP_L0, OP_L1, OP_L2
  } opnd_e;

  typedef enum logic [1:0] {SH_0, SH_32, SH_62} sh_e;

  typedef enum logic [2:0] {DST_NONE, DST_C0, DST_C1, DST_C2, DST_DOT} dst_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    logic  first;
    logic  sub;
    sh_e   sh;
    dst_e  dst;
  } mop_t;

  // multiply-accumulate program: distance squares, cross/dot, cross norm squares
  function automatic mop_t mac_prog(logic [4:0] idx);
    case (idx)
      5'd0:    mac_prog = '{OP_D0, OP_D0, 1'b1, 1'b0, SH_0,  DST_NONE};
      5'd1:    mac_prog = '{OP_D1, OP_D1, 1'b0, 1'b0, SH_0,  DST_NONE};
      5'd2:    mac_prog = '{OP_D2, OP_D2, 1'b0, 1'b0, SH_0,  DST_NONE};
      5'd3:    mac_prog = '{OP_A1, OP_B2, 1'b1, 1'b0, SH_0,  DST_NONE};
      5'd4:    mac_prog = '{OP_A2, OP_B1, 1'b0, 1'b1, SH_0,  DST_C0};
      5'd5:    mac_prog = '{OP_A2, OP_B0, 1'b1, 1'b0, SH_0,  DST_NONE};
      5'd6:    mac_prog = '{OP_A0, OP_B2, 1'b0, 1'b1, SH_0,  DST_C1};
      5'd7:    mac_prog = '{OP_A0, OP_B1, 1'b1, 1'b0, SH_0,  DST_NONE};
      5'd8:    mac_prog = '{OP_A1, OP_B0, 1'b0, 1'b1, SH_0,  DST_C2};
      5'd9:    mac_prog = '{OP_A0, OP_B0, 1'b1, 1'b0, SH_0,  DST_NONE};
      5'd10:   mac_prog = '{OP_A1, OP_B1, 1'b0, 1'b0, SH_0,  DST_NONE};
      5'd11:   mac_prog = '{OP_A2, OP_B2, 1'b0, 1'b0, SH_0,  DST_DOT};
      5'd12:   mac_prog = '{OP_H0, OP_H0, 1'b1, 1'b0, SH_62, DST_NONE};
      5'd13:   mac_prog = '{OP_H0, OP_L0, 1'b0, 1'b0, SH_32, DST_NONE};
      5'd14:   mac_prog = '{OP_L0, OP_L0, 1'b0, 1'b0, SH_0,  DST_NONE};
      5'd15:   mac_prog = '{OP_H1, OP_H1, 1'b0, 1'b0, SH_62, DST_NONE};
      5'd16:   mac_prog = '{OP_H1, OP_L1, 1'b0, 1'b0, SH_32, DST_NONE};
      5'd17:   mac_prog = '{OP_L1, OP_L1, 1'b0, 1'b0, SH_0,  DST_NONE};
      5'd18:   mac_prog = '{OP_H2, OP_H2, 1'b0, 1'b0, SH_62, DST_NONE};
      5'd19:   mac_prog = '{OP_H2, OP_L2, 1'b0, 1'b0, SH_32, DST_NONE};
      5'd20:   mac_prog = '{OP_L2, OP_L2, 1'b0, 1'b0, SH_0,  DST_NONE};
      default: mac_prog = '{OP_D0, OP_D0, 1'b0, 1'b0, SH_0,  DST_NONE};
    endcase
  endfunction

  // atan(2^-i) in units of pi scaled by 2^28
  function automatic logic [26:0] atan_val(logic [4:0] i);
    case (i)
      5'd0:    atan_val = 27'd67108864;
      5'd1:    atan_val = 27'd39616676;
      5'd2:    atan_val = 27'd20932363;
      5'd3:    atan_val = 27'd10625595;
      5'd4:    atan_val = 27'd5333416;
      5'd5:    atan_val = 27'd2669308;
      5'd6:    atan_val = 27'd1334980;
      5'd7:    atan_val = 27'd667531;
      5'd8:    atan_val = 27'd333770;
      5'd9:    atan_val = 27'd166886;
      5'd10:   atan_val = 27'd83443;
      5'd11:   atan_val = 27'd41722;
      5'd12:   atan_val = 27'd20861;
      5'd13:   atan_val = 27'd10430;
      5'd14:   atan_val = 27'd5215;
      5'd15:   atan_val = 27'd2608;
      5'd16:   atan_val = 27'd1304;
      5'd17:   atan_val = 27'd652;
      5'd18:   atan_val = 27'd326;
      5'd19:   atan_val = 27'd163;
      5'd20:   atan_val = 27'd81;
      5'd21:   atan_val = 27'd41;
      5'd22:   atan_val = 27'd20;
      5'd23:   atan_val = 27'd10;
      default: atan_val = 27'd0;
    endcase
  endfunction

endpackage

// File: hdl/pls_ctrl.sv
// Sequencer of the path length and smoothness block.
// Depends on pls_pkg and the assertion macro header.
`include "path_length_and_smoothness_macros.svh"

module pls_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pls_pkg::dp_stat_t st_i,
  output pls_pkg::dp_cmd_t  cmd_o
);
  import pls_pkg::*;

  localparam int COR_N = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_DMAC, S_DDRN, S_DSQI, S_DSQ, S_LEN, S_XMAC, S_XDRN,
    S_NMAC, S_NDRN, S_ASQI, S_ASQ, S_APREP, S_NORM, S_CINIT, S_CORD, S_TERM,
    S_CNT, S_DINIT, S_DIV, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [6:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = DP_NOP;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_d = 7'(MAC_D_FIRST);
        if (st_i.new_path) begin
          cmd_o.op = DP_PATH_NEW;
          state_d  = S_OUT;
        end else begin
          state_d = S_DMAC;
        end
      end
      S_DMAC: begin
        cmd_o.op = DP_MAC;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(MAC_D_LAST)) begin
          cnt_d   = '0;
          state_d = S_DDRN;
        end
      end
      S_DDRN: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd2) begin
          state_d = S_DSQI;
        end
      end
      S_DSQI: begin
        cmd_o.op = DP_SQ_INIT;
        cnt_d    = '0;
        state_d  = S_DSQ;
      end
      S_DSQ: begin
        cmd_o.op = DP_SQ_STEP;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(SQ_ITERS - 1)) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.op = DP_LEN_ADD;
        cnt_d    = 7'(MAC_X_FIRST);
        state_d  = st_i.cnt_ge2 ? S_XMAC : S_CNT;
      end
      S_XMAC: begin
        cmd_o.op = DP_MAC;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(MAC_X_LAST)) begin
          cnt_d   = '0;
          state_d = S_XDRN;
        end
      end
      S_XDRN: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd2) begin
          cnt_d   = 7'(MAC_N_FIRST);
          state_d = S_NMAC;
        end
      end
      S_NMAC: begin
        cmd_o.op = DP_MAC;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(MAC_N_LAST)) begin
          cnt_d   = '0;
          state_d = S_NDRN;
        end
      end
      S_NDRN: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd2) begin
          state_d = S_ASQI;
        end
      end
      S_ASQI: begin
        cmd_o.op = DP_SQ_INIT;
        cnt_d    = '0;
        state_d  = S_ASQ;
      end
      S_ASQ: begin
        cmd_o.op = DP_SQ_STEP;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(SQ_ITERS - 1)) begin
          state_d = S_APREP;
        end
      end
      S_APREP: begin
        cmd_o.op = DP_ANG_PREP;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (st_i.ang_zero) begin
          state_d = S_TERM;
        end else if (st_i.norm_done) begin
          state_d = S_CINIT;
        end else begin
          cmd_o.op = DP_NORM_STEP;
        end
      end
      S_CINIT: begin
        cmd_o.op = DP_COR_INIT;
        cnt_d    = '0;
        state_d  = S_CORD;
      end
      S_CORD: begin
        cmd_o.op = DP_COR_STEP;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(COR_N - 1)) begin
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        cmd_o.op = DP_TERM_ADD;
        state_d  = S_CNT;
      end
      S_CNT: begin
        cmd_o.op = DP_CNT_UPD;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cnt_d = '0;
        if (st_i.cnt_ge3) begin
          cmd_o.op = DP_DIV_INIT;
          state_d  = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(DIV_ITERS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!st_i.out_busy) begin
          cmd_o.op = DP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `PLS_ASSERT(a_accept_loads, (in_valid_i && in_ready_o) |-> (cmd_o.op == DP_LOAD))
  `PLS_ASSERT(a_out_to_idle, (state_q == S_OUT && !st_i.out_busy) |=> (state_q == S_IDLE))
  `PLS_ASSERT_NEVER(a_div_overrun, state_q == S_DIV && cnt_q >= 7'(DIV_ITERS))

endmodule

// File: hdl/pls_dpath.sv
// Datapath: point history, multiply-accumulate, square root, CORDIC, divider.
// Depends on pls_pkg and the assertion macro header.
`include "path_length_and_smoothness_macros.svh"

module pls_dpath #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic                          restart_i,
  input  pls_pkg::dp_cmd_t              cmd_i,
  output pls_pkg::dp_stat_t             st_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [47:0]                   path_length_o,
  output logic [31:0]                   segment_count_o,
  output logic [16:0]                   smoothness_avg_o,
  output logic                          smoothness_valid_o
);
  import pls_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int SH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;

  logic signed [COORD_WIDTH-1:0] p_q [3];
  logic signed [COORD_WIDTH-1:0] last_q [3];
  logic signed [COORD_WIDTH-1:0] slast_q [3];
  logic                          restart_q;

  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] len_q, sm_q;

  logic signed [DW-1:0] dd [3];
  logic signed [DW-1:0] ra [3];
  logic signed [DW-1:0] da [3];
  logic signed [DW-1:0] db [3];
  logic [30:0]          h_q [3];
  logic [30:0]          l_q [3];

  logic [NOPND*OPW-1:0]   opv;
  mop_t                   mop;
  logic signed [OPW-1:0]  opa, opb;
  logic signed [2*OPW-1:0] prod_q;
  logic                   pv_q, pfirst_q, psub_q;
  sh_e                    psh_q;
  dst_e                   pdst_q, sdst_q;
  logic signed [ACC_W-1:0] acc_q, addend, acc_base;
  logic [ACC_W-1:0]       cmag;
  logic signed [63:0]     dot_q;

  logic [ACC_W-1:0] rad_q;
  logic [67:0]      rem_q, rem2, trial;
  logic [63:0]      root_q;
  logic             sq_ge;

  logic [64:0] lsum;
  logic [48:0] ssum;

  logic [63:0] nx_q, ny_q, amx;
  logic        neg_q;

  logic signed [OPW-1:0] cx_q, cy_q, sx, sy;
  logic signed [31:0]    cz_q, zc, zdiff, zsum;
  logic [4:0]            ci;
  logic [AVG_W-1:0]      term, tval;

  logic [CNT_W-1:0] n_q, nn;
  logic [48:0]      dv_q, q_q;
  logic [32:0]      drem_q, r2;
  logic             dge;

  logic out_valid_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k] = DW'(p_q[k]) - DW'(last_q[k]);
      ra[k] = DW'(last_q[k]) - DW'(slast_q[k]);
      da[k] = ra[k] >>> SH;
      db[k] = dd[k] >>> SH;
    end
  end

  always_comb begin
    opv = '0;
    for (int k = 0; k < 3; k++) begin
      opv[(int'(OP_D0) + k)*OPW +: OPW] = OPW'(dd[k]);
      opv[(int'(OP_A0) + k)*OPW +: OPW] = OPW'(da[k]);
      opv[(int'(OP_B0) + k)*OPW +: OPW] = OPW'(db[k]);
      opv[(int'(OP_H0) + k)*OPW +: OPW] = OPW'(h_q[k]);
      opv[(int'(OP_L0) + k)*OPW +: OPW] = OPW'(l_q[k]);
    end
    mop = mac_prog(cmd_i.idx[4:0]);
    opa = $signed(opv[mop.a*OPW +: OPW]);
    opb = $signed(opv[mop.b*OPW +: OPW]);
  end

  always_comb begin
    case (psh_q)
      SH_32:   addend = ACC_W'(prod_q) <<< 32;
      SH_62:   addend = ACC_W'(prod_q) <<< 62;
      default: addend = ACC_W'(prod_q);
    endcase
    acc_base = pfirst_q ? '0 : acc_q;
    cmag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  end

  // square root, two radicand bits per step
  always_comb begin
    rem2  = {rem_q[65:0], rad_q[ACC_W-1:ACC_W-2]};
    trial = {2'b00, root_q, 2'b01};
    sq_ge = rem2 >= trial;
    lsum  = {17'd0, len_q} + {1'b0, root_q};
  end

  always_comb begin
    amx   = (ny_q > nx_q) ? ny_q : nx_q;
    ci    = cmd_i.idx[4:0];
    sx    = cx_q >>> ci;
    sy    = cy_q >>> ci;
    if (cz_q < 32'sd0) begin
      zc = 32'sd0;
    end else if (cz_q > HALF_TURN) begin
      zc = HALF_TURN;
    end else begin
      zc = cz_q;
    end
    zdiff = HALF_TURN - zc;
    zsum  = zdiff + 32'sd2048;
    term  = zsum[28:12];
    tval  = (amx == '0) ? AVG_ONE : term;
    ssum  = {1'b0, sm_q} + 49'(tval);
  end

  always_comb begin
    nn  = count_q - 32'd2;
    r2  = {drem_q[31:0], dv_q[48]};
    dge = r2 >= {1'b0, n_q};
  end

  always_comb begin
    st_o.new_path  = restart_q || (count_q == '0);
    st_o.cnt_ge2   = count_q >= 32'd2;
    st_o.cnt_ge3   = count_q >= 32'd3;
    st_o.ang_zero  = amx == '0;
    st_o.norm_done = (amx[63:29] == '0) && amx[28];
    st_o.out_busy  = out_valid_q && !out_ready_i;
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= 1'b0;
      sdst_q      <= DST_NONE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      len_q       <= '0;
      sm_q        <= '0;
      for (int k = 0; k < 3; k++) begin
        last_q[k]  <= '0;
        slast_q[k] <= '0;
      end
    end else begin
      pv_q   <= cmd_i.op == DP_MAC;
      sdst_q <= pv_q ? pdst_q : DST_NONE;
      if (cmd_i.op == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_PATH_NEW: begin
          count_q <= 32'd1;
          len_q   <= '0;
          sm_q    <= '0;
        end
        DP_LEN_ADD: begin
          len_q <= (lsum[64:48] != '0) ? SUM_MAX : lsum[47:0];
        end
        DP_TERM_ADD: begin
          sm_q <= ssum[48] ? SUM_MAX : ssum[47:0];
        end
        DP_CNT_UPD: begin
          if (count_q != CNT_MAX) begin
            count_q <= count_q + 32'd1;
          end
        end
        DP_OUT: begin
          for (int k = 0; k < 3; k++) begin
            slast_q[k] <= last_q[k];
            last_q[k]  <= p_q[k];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prod_q   <= opa * opb;
    pfirst_q <= mop.first;
    psub_q   <= mop.sub;
    psh_q    <= mop.sh;
    pdst_q   <= mop.dst;
    if (pv_q) begin
      acc_q <= psub_q ? acc_base - addend : acc_base + addend;
    end
    case (sdst_q)
      DST_C0: begin
        h_q[0] <= cmag[61:31];
        l_q[0] <= cmag[30:0];
      end
      DST_C1: begin
        h_q[1] <= cmag[61:31];
        l_q[1] <= cmag[30:0];
      end
      DST_C2: begin
        h_q[2] <= cmag[61:31];
        l_q[2] <= cmag[30:0];
      end
      DST_DOT: begin
        dot_q <= acc_q[63:0];
      end
      default: begin
      end
    endcase
    case (cmd_i.op)
      DP_LOAD: begin
        p_q[0]    <= pos_x_i;
        p_q[1]    <= pos_y_i;
        p_q[2]    <= pos_z_i;
        restart_q <= restart_i;
      end
      DP_SQ_INIT: begin
        rad_q  <= acc_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      DP_SQ_STEP: begin
        rad_q  <= rad_q << 2;
        rem_q  <= sq_ge ? rem2 - trial : rem2;
        root_q <= {root_q[62:0], sq_ge};
      end
      DP_ANG_PREP: begin
        ny_q  <= root_q;
        nx_q  <= dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
        neg_q <= dot_q[63];
      end
      DP_NORM_STEP: begin
        if (amx[63:29] != '0) begin
          nx_q <= nx_q >> 1;
          ny_q <= ny_q >> 1;
        end else begin
          nx_q <= nx_q << 1;
          ny_q <= ny_q << 1;
        end
      end
      DP_COR_INIT: begin
        if (neg_q) begin
          cx_q <= $signed(OPW'(ny_q[28:0]));
          cy_q <= $signed(OPW'(nx_q[28:0]));
          cz_q <= HALF_TURN >>> 1;
        end else begin
          cx_q <= $signed(OPW'(nx_q[28:0]));
          cy_q <= $signed(OPW'(ny_q[28:0]));
          cz_q <= 32'sd0;
        end
      end
      DP_COR_STEP: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + $signed(32'(atan_val(ci)));
        end else begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - $signed(32'(atan_val(ci)));
        end
      end
      DP_DIV_INIT: begin
        n_q    <= nn;
        dv_q   <= 49'(sm_q) + 49'(nn[31:1]);
        drem_q <= '0;
        q_q    <= '0;
      end
      DP_DIV_STEP: begin
        dv_q   <= dv_q << 1;
        drem_q <= dge ? r2 - {1'b0, n_q} : r2;
        q_q    <= {q_q[47:0], dge};
      end
      DP_OUT: begin
        path_length_o      <= len_q;
        segment_count_o    <= count_q - 32'd1;
        smoothness_valid_o <= st_o.cnt_ge3;
        if (!st_o.cnt_ge3) begin
          smoothness_avg_o <= '0;
        end else if (q_q > 49'(AVG_ONE)) begin
          smoothness_avg_o <= AVG_ONE;
        end else begin
          smoothness_avg_o <= q_q[16:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `PLS_ASSERT(a_norm_live, (cmd_i.op == DP_NORM_STEP) |-> (!st_o.norm_done && !st_o.ang_zero))
  `PLS_ASSERT(a_out_rise, $rose(out_valid_q) |-> $past(cmd_i.op == DP_OUT))
  `PLS_ASSERT(a_avg_range, out_valid_q |-> (smoothness_avg_o <= AVG_ONE))

endmodule

// File: hdl/path_length_and_smoothness.sv
// A path's first point needs only the load and the output step; its second adds the
// distance square root, and later points add the cross-norm square root, up to 35
// normalize shifts, the CORDIC and the divider (64-step square root, 49-step divider).
// One point in flight; the next is accepted once the result sits in the output register.
// Reset (rst_ni low, asynchronous) empties the path: the next point starts a new one.
module path_length_and_smoothness #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [47:0]                   path_length_o,
  output logic [31:0]                   segment_count_o,
  output logic [16:0]                   smoothness_avg_o,
  output logic                          smoothness_valid_o
);
  import pls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  pls_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pls_dpath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .restart_i          (restart_i),
    .cmd_i              (cmd),
    .st_o               (st),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .path_length_o      (path_length_o),
    .segment_count_o    (segment_count_o),
    .smoothness_avg_o   (smoothness_avg_o),
    .smoothness_valid_o (smoothness_valid_o)
  );

endmodule

// File: dv/pls_checker.sv
// Checker for path_length_and_smoothness: watches both channels, predicts each result
// and compares it field by field. Depends on nothing but the DUT's port widths.
`timescale 1ns / 1ps
module pls_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic               restart_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [47:0]        path_length_i,
  input  logic [31:0]        segment_count_i,
  input  logic [16:0]        smoothness_avg_i,
  input  logic               smoothness_valid_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int       STEPS     = 16;
  localparam longint   HALF_TURN = 64'sd268435456;
  localparam bit [63:0] SUM_MAX  = 64'hFFFF_FFFF_FFFF;
  localparam longint ATAN_TAB [24] = '{
    67108864, 39616676, 20932363, 10625595, 5333416, 2669308, 1334980,
    667531, 333770, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41, 20, 10
  };

  typedef struct {
    bit [47:0] len;
    bit [31:0] segs;
    bit [16:0] avg;
    bit        avg_ok;
  } path_res_t;

  path_res_t res_q[$];
  longint    last_pt [3];
  longint    prev_pt [3];
  bit [31:0] pt_cnt;
  bit [63:0] len_sum;
  bit [63:0] turn_sum;

  function automatic bit [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] root_floor(bit [127:0] s);
    bit [63:0]  r;
    bit [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= s) r = c[63:0];
    end
    return r;
  endfunction

  function automatic bit [63:0] norm3(bit [63:0] a, bit [63:0] b, bit [63:0] c);
    bit [127:0] s;
    s = {64'd0, a} * {64'd0, a} + {64'd0, b} * {64'd0, b} + {64'd0, c} * {64'd0, c};
    return root_floor(s);
  endfunction

  function automatic bit [63:0] turn_term(bit [63:0] y, longint xs);
    bit [63:0] xm, m;
    longint    x, yy, z, nx, ny;
    xm = abs64(xs);
    m  = y > xm ? y : xm;
    z  = 0;
    if (m == 0) return 64'd65536;
    while (m >= (64'd1 << 29)) begin
      m >>= 1; y >>= 1; xm >>= 1;
    end
    while (m < (64'd1 << 28)) begin
      m <<= 1; y <<= 1; xm <<= 1;
    end
    if (xs < 0) begin
      x = longint'(y); yy = longint'(xm); z = HALF_TURN / 2;
    end else begin
      x = longint'(xm); yy = longint'(y);
    end
    for (int i = 0; i < STEPS; i++) begin
      if (yy >= 0) begin
        nx = x + (yy >>> i); ny = yy - (x >>> i); z += ATAN_TAB[i];
      end else begin
        nx = x - (yy >>> i); ny = yy + (x >>> i); z -= ATAN_TAB[i];
      end
      x = nx; yy = ny;
    end
    if (z < 0) z = 0;
    if (z > HALF_TURN) z = HALF_TURN;
    return 64'(HALF_TURN - z + 2048) >> 12;
  endfunction

  function automatic bit [63:0] sat48(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return s > SUM_MAX ? SUM_MAX : s;
  endfunction

  function automatic path_res_t advance_path(longint p [3], bit restart);
    longint    a [3], b [3], c [3];
    longint    dot;
    bit [63:0] n, avg;
    path_res_t r;
    if (restart || pt_cnt == 0) begin
      pt_cnt = 1; len_sum = 0; turn_sum = 0;
    end else begin
      len_sum = sat48(len_sum, norm3(abs64(p[0] - last_pt[0]), abs64(p[1] - last_pt[1]),
                                     abs64(p[2] - last_pt[2])));
      if (pt_cnt >= 2) begin
        for (int k = 0; k < 3; k++) begin
          a[k] = last_pt[k] - prev_pt[k];
          b[k] = p[k] - last_pt[k];
        end
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        dot  = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        turn_sum = sat48(turn_sum,
                         turn_term(norm3(abs64(c[0]), abs64(c[1]), abs64(c[2])), dot));
      end
      if (pt_cnt != 32'hFFFF_FFFF) pt_cnt++;
    end
    for (int k = 0; k < 3; k++) begin
      prev_pt[k] = last_pt[k];
      last_pt[k] = p[k];
    end
    r.len  = len_sum[47:0];
    r.segs = pt_cnt - 1;
    if (pt_cnt >= 3) begin
      n   = 64'(pt_cnt) - 2;
      avg = (turn_sum + n / 2) / n;
      r.avg    = avg > 65536 ? 17'd65536 : avg[16:0];
      r.avg_ok = 1'b1;
    end else begin
      r.avg    = '0;
      r.avg_ok = 1'b0;
    end
    return r;
  endfunction

  task automatic cmp(string fld, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pt_cnt = 0; len_sum = 0; turn_sum = 0;
    for (int k = 0; k < 3; k++) begin
      last_pt[k] = 0; prev_pt[k] = 0;
    end
  end

  assign pending_o = res_q.size();

  always @(posedge clk_i) begin
    path_res_t e;
    longint    p [3];
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        p[0] = pos_x_i; p[1] = pos_y_i; p[2] = pos_z_i;
        res_q = {res_q, advance_path(p, restart_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (res_q.size() == 0) begin
          $display("%0t: unexpected transaction, length %0d", $time, path_length_i);
          fail_count_o++;
        end else begin
          e = res_q.pop_front();
          cmp("path_length", e.len, path_length_i);
          cmp("segment_count", e.segs, segment_count_i);
          cmp("smoothness_avg", e.avg, smoothness_avg_i);
          cmp("smoothness_valid", e.avg_ok, smoothness_valid_i);
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
// Testbench top for path_length_and_smoothness: drives trajectory points and output
// back-pressure, and gives the verdict. Depends on pls_checker and the DUT.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] pos_x_i = '0;
  logic signed [23:0] pos_y_i = '0;
  logic signed [23:0] pos_z_i = '0;
  logic               restart_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [47:0]        path_length_o;
  logic [31:0]        segment_count_o;
  logic [16:0]        smoothness_avg_o;
  logic               smoothness_valid_o;
  int                 fail_count;
  int                 pending;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycles = 0;
  logic signed [23:0] cur [3];

  always #6 clk_i = ~clk_i;

  path_length_and_smoothness u_dut (.*);

  pls_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .pos_x_i, .pos_y_i,
    .pos_z_i, .restart_i, .out_valid_i(out_valid_o), .out_ready_i,
    .path_length_i(path_length_o), .segment_count_i(segment_count_o),
    .smoothness_avg_i(smoothness_avg_o), .smoothness_valid_i(smoothness_valid_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z, logic r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= z; restart_i <= r;
    cur[0] = x; cur[1] = y; cur[2] = z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_point();
    int          mode, k;
    logic signed [23:0] p [3];
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      k = $urandom_range(1, 22);
      if (mode < 15) p[i] = 24'($urandom);
      else if (mode < 22) p[i] = cur[i];
      else p[i] = 24'(cur[i] + $signed(24'($urandom_range(0, 1 << k))) - (1 << (k - 1)));
    end
    send_point(p[0], p[1], p[2], $urandom_range(99) < 4);
  endtask

  localparam logic signed [23:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] PMIN = 24'sh800000;

  initial begin
    cur[0] = 0; cur[1] = 0; cur[2] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, restart, zero segment, straight, right angle, reversal
    send_point(PMAX, PMAX, PMAX, 1'b0);
    send_point(PMIN, PMIN, PMIN, 1'b0);
    send_point(PMAX, PMAX, PMAX, 1'b0);
    send_point(PMAX, PMAX, PMAX, 1'b0);
    send_point(PMIN, PMAX, 0, 1'b0);
    send_point(0, 0, 0, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(65536, 0, 0, 1'b1);
    send_point(131072, 0, 0, 1'b0);
    send_point(196608, 0, 0, 1'b0);
    send_point(196608, 65536, 0, 1'b0);
    send_point(196608, 65536, 65536, 1'b0);
    send_point(196608, 65536, 0, 1'b0);
    send_point(131072, 0, 0, 1'b0);
    send_point(131073, 1, -1, 1'b0);
    send_point(PMIN, PMAX, PMIN, 1'b1);
    send_point(PMAX, PMIN, PMAX, 1'b0);
    send_point(-1, 1, -1, 1'b0);
    send_point(PMIN, PMIN, PMAX, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 19 : 0;
      stall_pct = (ph == 2) ? 73 : (ph == 3) ? 19 : 0;
      repeat (358) random_point();
      drain();
    end

    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
